@@ rtl/core/ffha_pkg.sv @@
// Shared constants, codes and types for the first-fit heap allocator.
`default_nettype none
package ffha_pkg;

    localparam int unsigned HEAP_BYTES_DEF = 4096;
    localparam int unsigned HDR_BYTES      = 2;
    localparam int unsigned SZ_W           = 15;
    localparam int unsigned HDR_W          = 16;
    localparam int unsigned ADDR_W         = 12;
    localparam int unsigned ALU_W          = 18;

    localparam logic OP_ALLOC     = 1'b0;
    localparam logic OP_FREE      = 1'b1;
    localparam logic STAT_OK      = 1'b0;
    localparam logic STAT_NOSPACE = 1'b1;

    typedef enum logic [1:0] {
        ALU_ADD2 = 2'd0,
        ALU_SUB  = 2'd1,
        ALU_SUB2 = 2'd2
    } t_alu_op;

    typedef struct packed {
        t_alu_op            op;
        logic [ALU_W-1:0]   a;
        logic [ALU_W-1:0]   b;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0]   y;
        logic               neg;
        logic               zero;
    } t_alu_res;

endpackage
`default_nettype wire

@@ rtl/core/ffha_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ffha_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/ffha_alu.sv @@
// Shared add/subtract unit with sign and zero flags for the header walk.
`default_nettype none
module ffha_alu (
    input  wire ffha_pkg::t_alu_req i_req,
    output ffha_pkg::t_alu_res      o_res
);
    import ffha_pkg::*;

    localparam logic [ALU_W-1:0] HDR = ALU_W'(HDR_BYTES);

    logic [ALU_W-1:0] y;

    always_comb begin
        case (i_req.op)
            ALU_ADD2: y = i_req.a + i_req.b + HDR;
            ALU_SUB:  y = i_req.a - i_req.b;
            ALU_SUB2: y = i_req.a - i_req.b - HDR;
            default:  y = i_req.a + i_req.b;
        endcase
    end

    assign o_res.y    = y;
    assign o_res.neg  = y[ALU_W-1];
    assign o_res.zero = (y == '0);

endmodule
`default_nettype wire

@@ rtl/core/first_fit_heap_allocator_core.sv @@
// Allocate: per block, read the header, find its end, check the limit, test
// the fit; then write and report. Free walks up to the target, then merges;
// a merge rewrites both headers. One header RAM port paces every step.
// Throughput: one word at a time; input stalls until the result is taken.
// Reset: synchronous; after release ST_INIT seeds header 0, input stalled.
`default_nettype none
module first_fit_heap_allocator_core #(
    parameter int unsigned HEAP_BYTES = ffha_pkg::HEAP_BYTES_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic                        i_operation,
    input  wire logic [ffha_pkg::SZ_W-1:0]   i_request_size,
    input  wire logic [ffha_pkg::ADDR_W-1:0] i_block_address,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic      [ffha_pkg::ADDR_W-1:0] o_result_address,
    output logic                             o_status
);
    import ffha_pkg::*;

    localparam int unsigned AW = $clog2(HEAP_BYTES);
    localparam int unsigned PW = $clog2(HEAP_BYTES + 1);
    localparam int unsigned EW = $clog2(HEAP_BYTES + (1 << SZ_W) + HDR_BYTES);
    localparam logic [ALU_W-1:0] HEAP_A = ALU_W'(HEAP_BYTES);
    localparam logic [SZ_W-1:0]  INIT_SZ = SZ_W'(HEAP_BYTES - HDR_BYTES);

    typedef enum logic [21:0] {
        ST_INIT   = 22'h1 << 0,
        ST_IDLE   = 22'h1 << 1,
        ST_A_RD   = 22'h1 << 2,
        ST_A_END  = 22'h1 << 3,
        ST_A_LIM  = 22'h1 << 4,
        ST_A_FIT  = 22'h1 << 5,
        ST_A_SPL  = 22'h1 << 6,
        ST_A_SPW  = 22'h1 << 7,
        ST_A_RES  = 22'h1 << 8,
        ST_F_RD   = 22'h1 << 9,
        ST_F_END  = 22'h1 << 10,
        ST_F_LIM  = 22'h1 << 11,
        ST_F_CMP  = 22'h1 << 12,
        ST_M_RD   = 22'h1 << 13,
        ST_M_END  = 22'h1 << 14,
        ST_M_LIM  = 22'h1 << 15,
        ST_M_RDN  = 22'h1 << 16,
        ST_M_NEND = 22'h1 << 17,
        ST_M_NLIM = 22'h1 << 18,
        ST_M_MRG  = 22'h1 << 19,
        ST_M_MRW  = 22'h1 << 20,
        ST_DONE   = 22'h1 << 21
    } t_state;

    t_state            r_state, n_state;
    logic [PW-1:0]     r_pos, n_pos;
    logic [EW-1:0]     r_end, n_end;
    logic [EW-1:0]     r_nend, n_nend;
    logic [HDR_W-1:0]  r_cur, n_cur;
    logic [SZ_W-1:0]   r_req, n_req;
    logic [ADDR_W-1:0] r_baddr, n_baddr;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic              r_stat, n_stat;

    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [HDR_W-1:0]  ram_wdata, ram_rdata;
    t_alu_req          alu_req;
    t_alu_res          alu_res;

    logic              h_free;
    logic [SZ_W-1:0]   h_size;

    assign h_free = ram_rdata[0];
    assign h_size = ram_rdata[HDR_W-1:1];

    ffha_ram #(
        .WIDTH (HDR_W),
        .DEPTH (HEAP_BYTES)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ffha_alu u_alu (
        .i_req (alu_req),
        .o_res (alu_res)
    );

    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_end     = r_end;
        n_nend    = r_nend;
        n_cur     = r_cur;
        n_req     = r_req;
        n_baddr   = r_baddr;
        n_addr    = r_addr;
        n_stat    = r_stat;
        ram_we    = 1'b0;
        ram_waddr = r_pos[AW-1:0];
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = r_pos[AW-1:0];
        alu_req.op = ALU_ADD2;
        alu_req.a  = '0;
        alu_req.b  = '0;

        case (r_state)
            ST_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = {INIT_SZ, 1'b1};
                n_state   = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_request_size;
                    n_baddr = i_block_address;
                    n_pos   = '0;
                    n_state = (i_operation == OP_ALLOC) ? ST_A_RD : ST_F_RD;
                end
            end
            ST_A_RD: begin
                ram_re     = 1'b1;
                alu_req.op = ALU_SUB2;
                alu_req.a  = HEAP_A;
                alu_req.b  = ALU_W'(r_pos);
                if (alu_res.neg) begin
                    n_addr  = '0;
                    n_stat  = STAT_NOSPACE;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_A_END;
                end
            end
            ST_A_END: begin
                alu_req.op = ALU_ADD2;
                alu_req.a  = ALU_W'(r_pos);
                alu_req.b  = ALU_W'(h_size);
                n_end      = alu_res.y[EW-1:0];
                n_state    = ST_A_LIM;
            end
            ST_A_LIM: begin
                alu_req.op = ALU_SUB;
                alu_req.a  = HEAP_A;
                alu_req.b  = ALU_W'(r_end);
                if (alu_res.neg) begin
                    n_addr  = '0;
                    n_stat  = STAT_NOSPACE;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_A_FIT;
                end
            end
            ST_A_FIT: begin
                alu_req.op = ALU_SUB;
                alu_req.a  = ALU_W'(h_size);
                alu_req.b  = ALU_W'(r_req);
                if (h_free && !alu_res.neg) begin
                    n_state = ST_A_SPL;
                end else begin
                    n_pos   = r_end[PW-1:0];
                    n_state = ST_A_RD;
                end
            end
            ST_A_SPL: begin
                alu_req.op = ALU_SUB2;
                alu_req.a  = ALU_W'(h_size);
                alu_req.b  = ALU_W'(r_req);
                ram_we     = 1'b1;
                if (!alu_res.neg && !alu_res.zero) begin
                    ram_wdata = {r_req, 1'b0};
                    n_end     = alu_res.y[EW-1:0];
                    n_state   = ST_A_SPW;
                end else begin
                    ram_wdata = {h_size, 1'b0};
                    n_state   = ST_A_RES;
                end
            end
            ST_A_SPW: begin
                // remainder header sits just past the requested payload
                alu_req.op = ALU_ADD2;
                alu_req.a  = ALU_W'(r_pos);
                alu_req.b  = ALU_W'(r_req);
                ram_we     = 1'b1;
                ram_waddr  = alu_res.y[AW-1:0];
                ram_wdata  = {r_end[SZ_W-1:0], 1'b1};
                n_state    = ST_A_RES;
            end
            ST_A_RES: begin
                alu_req.op = ALU_ADD2;
                alu_req.a  = ALU_W'(r_pos);
                alu_req.b  = '0;
                n_addr     = alu_res.y[ADDR_W-1:0];
                n_stat     = STAT_OK;
                n_state    = ST_DONE;
            end
            ST_F_RD: begin
                ram_re     = 1'b1;
                alu_req.op = ALU_SUB2;
                alu_req.a  = HEAP_A;
                alu_req.b  = ALU_W'(r_pos);
                if (alu_res.neg) begin
                    n_pos   = '0;
                    n_state = ST_M_RD;
                end else begin
                    n_state = ST_F_END;
                end
            end
            ST_F_END: begin
                alu_req.op = ALU_ADD2;
                alu_req.a  = ALU_W'(r_pos);
                alu_req.b  = ALU_W'(h_size);
                n_end      = alu_res.y[EW-1:0];
                n_state    = ST_F_LIM;
            end
            ST_F_LIM: begin
                alu_req.op = ALU_SUB;
                alu_req.a  = HEAP_A;
                alu_req.b  = ALU_W'(r_end);
                if (alu_res.neg) begin
                    n_pos   = '0;
                    n_state = ST_M_RD;
                end else begin
                    n_state = ST_F_CMP;
                end
            end
            ST_F_CMP: begin
                alu_req.op = ALU_SUB2;
                alu_req.a  = ALU_W'(r_baddr);
                alu_req.b  = ALU_W'(r_pos);
                if (alu_res.zero) begin
                    if (!h_free) begin
                        ram_we    = 1'b1;
                        ram_wdata = {h_size, 1'b1};
                    end
                    n_pos   = '0;
                    n_state = ST_M_RD;
                end else if (alu_res.neg) begin
                    n_pos   = '0;
                    n_state = ST_M_RD;
                end else begin
                    n_pos   = r_end[PW-1:0];
                    n_state = ST_F_RD;
                end
            end
            ST_M_RD: begin
                ram_re     = 1'b1;
                alu_req.op = ALU_SUB2;
                alu_req.a  = HEAP_A;
                alu_req.b  = ALU_W'(r_pos);
                if (alu_res.neg) begin
                    n_addr  = '0;
                    n_stat  = STAT_OK;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_M_END;
                end
            end
            ST_M_END: begin
                alu_req.op = ALU_ADD2;
                alu_req.a  = ALU_W'(r_pos);
                alu_req.b  = ALU_W'(h_size);
                n_end      = alu_res.y[EW-1:0];
                n_cur      = ram_rdata;
                n_state    = ST_M_LIM;
            end
            ST_M_LIM: begin
                alu_req.op = ALU_SUB;
                alu_req.a  = HEAP_A;
                alu_req.b  = ALU_W'(r_end);
                if (alu_res.neg) begin
                    n_addr  = '0;
                    n_stat  = STAT_OK;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_M_RDN;
                end
            end
            ST_M_RDN: begin
                ram_re     = 1'b1;
                ram_raddr  = r_end[AW-1:0];
                alu_req.op = ALU_SUB2;
                alu_req.a  = HEAP_A;
                alu_req.b  = ALU_W'(r_end);
                if (alu_res.neg) begin
                    n_addr  = '0;
                    n_stat  = STAT_OK;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_M_NEND;
                end
            end
            ST_M_NEND: begin
                alu_req.op = ALU_ADD2;
                alu_req.a  = ALU_W'(r_end);
                alu_req.b  = ALU_W'(h_size);
                n_nend     = alu_res.y[EW-1:0];
                n_state    = ST_M_NLIM;
            end
            ST_M_NLIM: begin
                alu_req.op = ALU_SUB;
                alu_req.a  = HEAP_A;
                alu_req.b  = ALU_W'(r_nend);
                if (alu_res.neg) begin
                    n_addr  = '0;
                    n_stat  = STAT_OK;
                    n_state = ST_DONE;
                end else if (r_cur[0] && h_free) begin
                    n_state = ST_M_MRG;
                end else begin
                    n_pos   = r_end[PW-1:0];
                    n_state = ST_M_RD;
                end
            end
            ST_M_MRG: begin
                ram_we    = 1'b1;
                ram_waddr = r_end[AW-1:0];
                ram_wdata = '0;
                n_state   = ST_M_MRW;
            end
            ST_M_MRW: begin
                // absorbed header bytes go back into the payload
                alu_req.op = ALU_ADD2;
                alu_req.a  = ALU_W'(r_cur[HDR_W-1:1]);
                alu_req.b  = ALU_W'(h_size);
                ram_we     = 1'b1;
                ram_wdata  = {alu_res.y[SZ_W-1:0], 1'b1};
                n_state    = ST_M_RD;
            end
            ST_DONE: begin
                if (!i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
        r_pos   <= n_pos;
        r_end   <= n_end;
        r_nend  <= n_nend;
        r_cur   <= n_cur;
        r_req   <= n_req;
        r_baddr <= n_baddr;
        r_addr  <= n_addr;
        r_stat  <= n_stat;
    end

    assign o_in_stall       = (r_state != ST_IDLE);
    assign o_out_valid      = (r_state == ST_DONE);
    assign o_result_address = r_addr;
    assign o_status         = r_stat;

endmodule
`default_nettype wire

@@ rtl/core/ffha_checker.sv @@
// Port-level checks for the heap allocator, bound to the top level.
`default_nettype none
module ffha_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        o_in_stall,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_stall,
    input wire logic [ffha_pkg::ADDR_W-1:0] o_result_address,
    input wire logic                        o_status
);
    import ffha_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_result_address) && $stable(o_status))
        else $error("result word changed while stalled");

    a_busy_on_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while a result word waits");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == STAT_NOSPACE) |-> o_result_address == '0)
        else $error("failed allocate reports a non-zero address");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall && !o_out_valid)
        else $error("block not busy after taking a word");

endmodule

bind first_fit_heap_allocator_core ffha_checker u_ffha_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_result_address (o_result_address),
    .o_status         (o_status)
);
`default_nettype wire
